[rtl/core/infix_to_postfix_converter_core_macros.svh]
// Assertion macros used by the checker file of the infix to postfix converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and ignored in reset.
`define I2P_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and ignored in reset.
`define I2P_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/i2p_pkg.sv]
// Shared types, constants and precedence functions of the infix to postfix converter.
package i2p_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_VALID   = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    localparam logic signed [15:0] RANK_MAX = 16'sd32767;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the accepted transaction and read the stack top
        logic set_fail;   // mark the current expression as failed
        logic pop;        // pop the top into the pending slot, emitting the old pending
        logic push;       // push the current symbol
        logic drop;       // discard the top on a matching pair
        logic emit_pend;  // emit the pending character
        logic emit_stat;  // emit the status result and settle the parser state
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic err;
        logic in_space;
        logic in_end;
        logic cnt_zero;
        logic cnt_one;
        logic cnt_full;
        logic top_gt;
        logic top_eq;
        logic rank_low;
        logic pend_valid;
        logic fail;
        logic is_end;
    } t_dp_stat;

    // Incoming precedence.
    function automatic logic [3:0] f_prec_in(input logic [7:0] c);
        logic [3:0] p;
        case (c)
            CH_PLUS, CH_MINUS: p = 4'd1;
            CH_STAR, CH_SLASH: p = 4'd3;
            CH_CARET:          p = 4'd6;
            CH_LPAREN:         p = 4'd9;
            CH_RPAREN:         p = 4'd0;
            default:           p = 4'd7;
        endcase
        return p;
    endfunction

    // In-stack precedence.
    function automatic logic [3:0] f_prec_stk(input logic [7:0] c);
        logic [3:0] p;
        case (c)
            CH_PLUS, CH_MINUS: p = 4'd2;
            CH_STAR, CH_SLASH: p = 4'd4;
            CH_CARET:          p = 4'd5;
            CH_LPAREN:         p = 4'd0;
            default:           p = 4'd8;
        endcase
        return p;
    endfunction

    function automatic logic f_is_alnum(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

[rtl/core/infix_to_postfix_converter_core.sv]
// Infix to postfix converter: one ASCII character per input transaction goes in, and
// postfix characters come out as soon as the operator-precedence parser knows them.
// Every output transaction carries a character (kind 0) or a status (kind 1 valid,
// kind 2 invalid), and last marks the final result caused by an input transaction.
// An end transaction closes the expression with an implied ')', always produces a
// status, and returns the block to its reset state; after an error, characters are
// dropped until the end transaction. A space, or any character after an error, is
// taken in the idle state. Other characters are compared with the stack top, popping
// an entry per compare, then pushed or dropped, then a held popped character and, for
// an end or a failure, a status are delivered; an empty stack, a rank error on a pop,
// or an end transaction after an error skips the final compare. The pop loop is set
// by the single registered read port of the operator stack, which yields one new
// stack top per cycle while the output is free. A stalled output holds the parser
// until the output register frees up; no new input is taken until the current one is
// done. Stack entry zero is the '(' sentinel and needs no clearing pass after reset.
module infix_to_postfix_converter_core
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input channel.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_expr,
    // Output channel.
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic [1:0] o_kind,
    output logic       o_last
);

    // Command and status buses between the controller and the datapath.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The controller sequences each transaction: accept, compare and pop, push,
    // then deliver the held popped character and the status.
    i2p_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    // The datapath holds the operator stack, rank count, error flags and the output
    // register. A popped character is held one step so that its last flag is known.
    i2p_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_char     (i_in_char),
        .i_end_of_expr (i_end_of_expr),
        .i_stall       (i_stall),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_out_char    (o_out_char),
        .o_kind        (o_kind),
        .o_last        (o_last)
    );

endmodule

[rtl/core/i2p_ctrl.sv]
// Controller state machine of the infix to postfix converter.
module i2p_ctrl
    import i2p_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_stall
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_PEND = 2'd2;
    localparam logic [1:0] S_STAT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_stat.in_end) begin
                        o_cmd.load = 1'b1;
                        if (i_stat.err || i_stat.cnt_zero) begin
                            o_cmd.set_fail = 1'b1;
                            n_state = S_STAT;
                        end else begin
                            n_state = S_CMP;
                        end
                    end else if (!i_stat.err && !i_stat.in_space) begin
                        o_cmd.load = 1'b1;
                        if (i_stat.cnt_zero) begin
                            o_cmd.set_fail = 1'b1;
                            n_state = S_STAT;
                        end else begin
                            n_state = S_CMP;
                        end
                    end
                end
            end
            S_CMP: begin
                if (i_stat.out_free) begin
                    if (i_stat.top_gt) begin
                        o_cmd.pop = 1'b1;
                        if (i_stat.rank_low || i_stat.cnt_one) begin
                            o_cmd.set_fail = 1'b1;
                            n_state = S_PEND;
                        end
                    end else if (!i_stat.top_eq && i_stat.cnt_full) begin
                        o_cmd.set_fail = 1'b1;
                        n_state = i_stat.pend_valid ? S_PEND : S_STAT;
                    end else begin
                        o_cmd.push = !i_stat.top_eq;
                        o_cmd.drop = i_stat.top_eq;
                        if (i_stat.pend_valid) begin
                            n_state = S_PEND;
                        end else if (i_stat.is_end) begin
                            n_state = S_STAT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_PEND: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_pend = 1'b1;
                    n_state = (i_stat.fail || i_stat.is_end) ? S_STAT : S_IDLE;
                end
            end
            S_STAT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_stat = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/i2p_dp.sv]
// Datapath of the infix to postfix converter: operator stack, rank, flags and output register.
module i2p_dp
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_expr,
    input  logic       i_stall,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    output logic       o_valid,
    output logic [7:0] o_out_char,
    output logic [1:0] o_kind,
    output logic       o_last
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [7:0]        r_mem [STACK_DEPTH];
    logic [7:0]        r_rd_q;
    logic              r_rd_zero;
    logic [CW-1:0]     r_count,      n_count;
    logic signed [15:0] r_rank,      n_rank;
    logic              r_err,        n_err;
    logic              r_fail,       n_fail;
    logic              r_pend_valid, n_pend_valid;
    logic              r_ovalid,     n_ovalid;
    logic [7:0]        r_sym;
    logic              r_end;
    logic [7:0]        r_pend_char;
    logic [7:0]        r_ochar;
    logic [1:0]        r_okind;
    logic              r_olast;

    logic [7:0]        w_top;
    logic [3:0]        w_g;
    logic [3:0]        w_f;
    logic signed [15:0] w_rank_pop;
    logic [CW-1:0]     w_cnt_m1;
    logic [CW-1:0]     w_cnt_m2;
    logic [AW-1:0]     w_rd_addr;
    logic              w_emit;

    // Entry zero always holds the sentinel, so it is never written and reads as '('.
    assign w_top    = r_rd_zero ? CH_LPAREN : r_rd_q;
    assign w_g      = f_prec_stk(w_top);
    assign w_f      = f_prec_in(r_sym);
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cnt_m2 = r_count - CW'(2);
    assign w_rd_addr = i_cmd.load ? w_cnt_m1[AW-1:0] : w_cnt_m2[AW-1:0];

    always_comb begin
        if (f_is_alnum(w_top)) begin
            w_rank_pop = (r_rank < RANK_MAX) ? r_rank + 16'sd1 : r_rank;
        end else begin
            w_rank_pop = r_rank - 16'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[AW-1:0]] <= r_sym;
        end
        if (i_cmd.load || i_cmd.pop) begin
            r_rd_q    <= r_mem[w_rd_addr];
            r_rd_zero <= (w_rd_addr == '0);
        end
    end

    assign w_emit = (i_cmd.pop && r_pend_valid) || i_cmd.emit_pend || i_cmd.emit_stat;

    always_comb begin
        n_count      = r_count;
        n_rank       = r_rank;
        n_err        = r_err;
        n_fail       = r_fail;
        n_pend_valid = r_pend_valid;
        n_ovalid     = r_ovalid;

        if (i_cmd.load) begin
            n_fail       = 1'b0;
            n_pend_valid = 1'b0;
        end
        if (i_cmd.set_fail) begin
            n_fail = 1'b1;
        end
        if (i_cmd.pop) begin
            n_count      = w_cnt_m1;
            n_rank       = w_rank_pop;
            n_pend_valid = 1'b1;
        end
        if (i_cmd.drop) begin
            n_count = w_cnt_m1;
        end
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.emit_pend) begin
            n_pend_valid = 1'b0;
        end
        if (i_cmd.emit_stat) begin
            n_fail = 1'b0;
            if (r_end) begin
                n_count = CW'(1);
                n_rank  = '0;
                n_err   = 1'b0;
            end else begin
                n_err = r_err | r_fail;
            end
        end

        if (w_emit) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= CW'(1);
            r_rank       <= '0;
            r_err        <= 1'b0;
            r_fail       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_rank       <= n_rank;
            r_err        <= n_err;
            r_fail       <= n_fail;
            r_pend_valid <= n_pend_valid;
            r_ovalid     <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym <= i_end_of_expr ? CH_RPAREN : i_in_char;
            r_end <= i_end_of_expr;
        end
        if (i_cmd.pop) begin
            r_pend_char <= w_top;
        end
        if (i_cmd.emit_stat) begin
            r_ochar <= CH_NUL;
            r_olast <= 1'b1;
            if (!r_fail && (r_count == '0) && (r_rank == 16'sd1)) begin
                r_okind <= KIND_VALID;
            end else begin
                r_okind <= KIND_INVALID;
            end
        end else if (w_emit) begin
            r_ochar <= r_pend_char;
            r_okind <= KIND_CHAR;
            r_olast <= i_cmd.emit_pend && !(r_fail || r_end);
        end
    end

    assign o_stat.out_free   = !r_ovalid || !i_stall;
    assign o_stat.err        = r_err;
    assign o_stat.in_space   = (i_in_char == CH_SPACE);
    assign o_stat.in_end     = i_end_of_expr;
    assign o_stat.cnt_zero   = (r_count == '0);
    assign o_stat.cnt_one    = (r_count == CW'(1));
    assign o_stat.cnt_full   = (r_count >= CW'(STACK_DEPTH));
    assign o_stat.top_gt     = (w_g > w_f);
    assign o_stat.top_eq     = (w_g == w_f);
    assign o_stat.rank_low   = (w_rank_pop < 16'sd1);
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.fail       = r_fail;
    assign o_stat.is_end     = r_end;

    assign o_valid    = r_ovalid;
    assign o_out_char = r_ochar;
    assign o_kind     = r_okind;
    assign o_last     = r_olast;

endmodule

[rtl/core/i2p_checker.sv]
// Port-level assertion checker for the infix to postfix converter, bound to the top level.
`include "infix_to_postfix_converter_core_macros.svh"

module i2p_checker
    import i2p_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_char,
    input logic [1:0] o_kind,
    input logic       o_last
);

    `I2P_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_out_char) && $stable(o_kind) && $stable(o_last), "stalled output transaction changed")

    `I2P_ASSERT_NOW(a_stat_last, o_valid && (o_kind != KIND_CHAR), o_last, "status result not marked last")

    `I2P_ASSERT_NOW(a_stat_char, o_valid && (o_kind != KIND_CHAR), o_out_char == CH_NUL, "status result carries a character")

    `I2P_ASSERT_NOW(a_kind_code, o_valid, (o_kind == KIND_CHAR) || (o_kind == KIND_VALID) || (o_kind == KIND_INVALID), "undefined result kind")

endmodule

bind infix_to_postfix_converter_core i2p_checker u_i2p_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_char (o_out_char),
    .o_kind     (o_kind),
    .o_last     (o_last)
);
